@@ src/cir_pkg.sv @@
// cir_pkg: shared types, constants and helpers for the contact impulse resolver.
// No dependencies.
package cir_pkg;

   localparam int COMP_W   = 20;
   localparam int VEC_W    = 3 * COMP_W;
   localparam int NRM_W    = 16;
   localparam int IMASS_W  = 24;
   localparam int FRAC_W   = 17;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 1;

   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

   // divider: quotient in [0, 65536] for a nonzero divisor
   localparam int DIVD_W = 41;
   localparam int DSR_W  = 25;
   localparam int QUO_W  = 17;

   // accept to result strobe
   localparam int LATENCY = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAC = 1'b1;

   localparam logic [CSR_W-1:0]  SLOP_RESET = 20'd1;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd52429;

   typedef enum logic [1:0] {
      OUT_STATIC   = 2'd0,
      OUT_SEPARATE = 2'd1,
      OUT_IMPULSE  = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [IMASS_W-1:0] inv_mass_a;
      logic [IMASS_W-1:0] inv_mass_b;
      logic [VEC_W-1:0]   vel_a;
      logic [VEC_W-1:0]   vel_b;
      logic [3*NRM_W-1:0] contact_normal;
      logic [COMP_W-1:0]  penetration;
      logic [FRAC_W-1:0]  bounce_a;
      logic [FRAC_W-1:0]  bounce_b;
   } req_type;

   typedef struct packed {
      logic [VEC_W-1:0] shift_a;
      logic [VEC_W-1:0] shift_b;
      logic [VEC_W-1:0] new_vel_a;
      logic [VEC_W-1:0] new_vel_b;
      outcome_type      outcome;
   } rsp_type;

   function automatic logic [COMP_W-1:0] sat20(input logic signed [33:0] x);
      logic [COMP_W-1:0] r;
      if (x > 34'sd524287)
         r = 20'h7FFFF;
      else if (x < -34'sd524288)
         r = 20'h80000;
      else
         r = x[COMP_W-1:0];
      return r;
   endfunction

   function automatic logic [FRAC_W-1:0] clamp_one(input logic [FRAC_W-1:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

endpackage

@@ src/contact_impulse_resolver.sv @@
// contact_impulse_resolver: impulse contact response with positional correction.
// Depends on cir_pkg and cir_div.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+----------------------------------
//  input   | start, busy, req_data              | item taken when start && !busy
//  result  | rsp_valid, rsp_data                | one-cycle strobe, cannot stall
//  config  | csr_we, csr_index, csr_wdata       | write on csr_we, no read-back
//
// One item can enter every cycle while busy is low. Each item passes through the
// capture stage, the two 17-stage mass-share dividers, a product stage and a
// round/saturate stage. busy is high only during reset.
// reset is synchronous: it clears the valid bits and restores the config registers.
// No stalls exist anywhere in the pipeline.
module contact_impulse_resolver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cir_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output cir_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [cir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cir_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int DLY = 11;   // aligns the side path (6 stages) with the dividers (17)

   typedef struct packed {
      logic                               zero;
      logic                               sep;
      logic [cir_pkg::VEC_W-1:0]          va;
      logic [cir_pkg::VEC_W-1:0]          vb;
      logic [2:0][37:0]                   nc;
      logic [2:0][43:0]                   nw;
   } side_type;

   // ---------------- configuration registers ----------------
   logic [cir_pkg::CSR_W-1:0]  slop_ff;
   logic [cir_pkg::FRAC_W-1:0] frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff <= cir_pkg::SLOP_RESET;
         frac_ff <= cir_pkg::FRAC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cir_pkg::CSR_SLOP: slop_ff <= csr_wdata;
            cir_pkg::CSR_FRAC: frac_ff <= csr_wdata[cir_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // ---------------- stage 0: capture ----------------
   logic             v0_ff;
   cir_pkg::req_type d0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start && !busy;
      d0_ff <= req_data;
   end

   // mass shares: fa = round(ia*2^16/sum), fb likewise
   logic [cir_pkg::DSR_W-1:0]  sum0;
   logic [cir_pkg::DIVD_W-1:0] dvd_a0, dvd_b0;
   logic [cir_pkg::QUO_W-1:0]  fa_q, fb_q;

   assign sum0   = {1'b0, d0_ff.inv_mass_a} + {1'b0, d0_ff.inv_mass_b};
   assign dvd_a0 = {1'b0, d0_ff.inv_mass_a, 16'd0} + {17'd0, sum0[cir_pkg::DSR_W-1:1]};
   assign dvd_b0 = {1'b0, d0_ff.inv_mass_b, 16'd0} + {17'd0, sum0[cir_pkg::DSR_W-1:1]};

   cir_div u_div_a (.clock(clock), .dividend(dvd_a0), .divisor(sum0), .quotient(fa_q));
   cir_div u_div_b (.clock(clock), .dividend(dvd_b0), .divisor(sum0), .quotient(fb_q));

   // ---------------- stage 1: penetration product, normal-velocity terms -------
   logic                         v1_ff, zero1_ff;
   logic [2:0][15:0]             n1_ff;
   logic [cir_pkg::VEC_W-1:0]    va1_ff, vb1_ff;
   logic [36:0]                  cp1_ff;
   logic [2:0][36:0]             vp1_ff;
   logic [cir_pkg::FRAC_W-1:0]   e1_ff;

   logic [cir_pkg::COMP_W-1:0]   pen_in;
   logic [cir_pkg::FRAC_W-1:0]   ea_in, eb_in;
   logic [2:0][36:0]             vp_in;

   always_comb begin
      logic signed [20:0] dv;
      pen_in = (d0_ff.penetration > slop_ff) ? d0_ff.penetration - slop_ff : '0;
      ea_in  = cir_pkg::clamp_one(d0_ff.bounce_a);
      eb_in  = cir_pkg::clamp_one(d0_ff.bounce_b);
      for (int i = 0; i < 3; i++) begin
         dv = $signed({d0_ff.vel_b[20*i+19], d0_ff.vel_b[20*i +: 20]})
            - $signed({d0_ff.vel_a[20*i+19], d0_ff.vel_a[20*i +: 20]});
         vp_in[i] = $signed(d0_ff.contact_normal[16*i +: 16]) * dv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      zero1_ff <= (sum0 == '0);
      for (int i = 0; i < 3; i++) n1_ff[i] <= d0_ff.contact_normal[16*i +: 16];
      va1_ff <= d0_ff.vel_a;
      vb1_ff <= d0_ff.vel_b;
      cp1_ff <= {17'd0, pen_in} * {20'd0, cir_pkg::clamp_one(frac_ff)};
      vp1_ff <= vp_in;
      e1_ff  <= (ea_in < eb_in) ? ea_in : eb_in;
   end

   // ---------------- stage 2: corr rounding, vn sum ----------------
   logic                         v2_ff, zero2_ff;
   logic [2:0][15:0]             n2_ff;
   logic [cir_pkg::VEC_W-1:0]    va2_ff, vb2_ff;
   logic [20:0]                  corr2_ff;
   logic signed [38:0]           vn2_ff;
   logic [cir_pkg::FRAC_W-1:0]   e2_ff;
   logic [36:0]                  cr_in;

   assign cr_in = (cp1_ff + 37'd32768) >> 16;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      zero2_ff <= zero1_ff;
      n2_ff    <= n1_ff;
      va2_ff   <= va1_ff;
      vb2_ff   <= vb1_ff;
      corr2_ff <= cr_in[20:0];
      vn2_ff   <= 39'($signed(vp1_ff[0])) + 39'($signed(vp1_ff[1]))
                + 39'($signed(vp1_ff[2]));
      e2_ff    <= e1_ff;
   end

   // ---------------- stage 3: approach speed, n*corr ----------------
   logic                         v3_ff, zero3_ff, sep3_ff;
   logic [2:0][15:0]             n3_ff;
   logic [cir_pkg::VEC_W-1:0]    va3_ff, vb3_ff;
   logic [24:0]                  m3_ff;
   logic [2:0][37:0]             nc3_ff;
   logic [cir_pkg::FRAC_W-1:0]   e3_ff;
   logic [38:0]                  m_in;

   assign m_in = (39'(-vn2_ff) + 39'd8192) >> 14;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      zero3_ff <= zero2_ff;
      sep3_ff  <= (vn2_ff > 39'sd0);
      n3_ff    <= n2_ff;
      va3_ff   <= va2_ff;
      vb3_ff   <= vb2_ff;
      m3_ff    <= (vn2_ff > 39'sd0) ? '0 : m_in[24:0];
      for (int i = 0; i < 3; i++)
         nc3_ff[i] <= $signed(n2_ff[i]) * $signed({1'b0, corr2_ff});
      e3_ff    <= e2_ff;
   end

   // ---------------- stage 4: (1+e)*m ----------------
   logic                         v4_ff, zero4_ff, sep4_ff;
   logic [2:0][15:0]             n4_ff;
   logic [cir_pkg::VEC_W-1:0]    va4_ff, vb4_ff;
   logic [2:0][37:0]             nc4_ff;
   logic [42:0]                  wp4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      zero4_ff <= zero3_ff;
      sep4_ff  <= sep3_ff;
      n4_ff    <= n3_ff;
      va4_ff   <= va3_ff;
      vb4_ff   <= vb3_ff;
      nc4_ff   <= nc3_ff;
      wp4_ff   <= ({25'd0, cir_pkg::ONE_Q16 + {1'b0, e3_ff[15:0]}}
                  + (e3_ff[16] ? 43'd65536 : 43'd0)) * {18'd0, m3_ff};
   end

   // ---------------- stage 5: w rounding ----------------
   logic                         v5_ff, zero5_ff, sep5_ff;
   logic [2:0][15:0]             n5_ff;
   logic [cir_pkg::VEC_W-1:0]    va5_ff, vb5_ff;
   logic [2:0][37:0]             nc5_ff;
   logic [26:0]                  w5_ff;
   logic [42:0]                  w_in;

   assign w_in = (wp4_ff + 43'd32768) >> 16;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      zero5_ff <= zero4_ff;
      sep5_ff  <= sep4_ff;
      n5_ff    <= n4_ff;
      va5_ff   <= va4_ff;
      vb5_ff   <= vb4_ff;
      nc5_ff   <= nc4_ff;
      w5_ff    <= w_in[26:0];
   end

   // ---------------- stage 6: n*w, then delay line ----------------
   logic     v6_ff;
   side_type s6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      s6_ff.zero <= zero5_ff;
      s6_ff.sep  <= sep5_ff;
      s6_ff.va   <= va5_ff;
      s6_ff.vb   <= vb5_ff;
      s6_ff.nc   <= nc5_ff;
      for (int i = 0; i < 3; i++)
         s6_ff.nw[i] <= $signed(n5_ff[i]) * $signed({1'b0, w5_ff});
   end

   logic     dv_ff [DLY];
   side_type ds_ff [DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) dv_ff[k] <= 1'b0;
      end else begin
         dv_ff[0] <= v6_ff;
         for (int k = 1; k < DLY; k++) dv_ff[k] <= dv_ff[k-1];
      end
      ds_ff[0] <= s6_ff;
      for (int k = 1; k < DLY; k++) ds_ff[k] <= ds_ff[k-1];
   end

   // ---------------- product stage: scale by mass shares ----------------
   logic                         vp_ff, zp_ff, sp_ff;
   logic [cir_pkg::VEC_W-1:0]    vap_ff, vbp_ff;
   logic signed [55:0]           pa_ff [3];
   logic signed [55:0]           pb_ff [3];
   logic signed [61:0]           qa_ff [3];
   logic signed [61:0]           qb_ff [3];
   side_type                     sd;

   assign sd = ds_ff[DLY-1];

   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else       vp_ff <= dv_ff[DLY-1];
      zp_ff  <= sd.zero;
      sp_ff  <= sd.sep;
      vap_ff <= sd.va;
      vbp_ff <= sd.vb;
      for (int i = 0; i < 3; i++) begin
         pa_ff[i] <= $signed(sd.nc[i]) * $signed({1'b0, fa_q});
         pb_ff[i] <= $signed(sd.nc[i]) * $signed({1'b0, fb_q});
         qa_ff[i] <= $signed(sd.nw[i]) * $signed({1'b0, fa_q});
         qb_ff[i] <= $signed(sd.nw[i]) * $signed({1'b0, fb_q});
      end
   end

   // ---------------- output stage: round half away, saturate, select -------
   // round(x / 2^30) with ties away from zero == (x + 2^29 - neg) >>> 30
   cir_pkg::rsp_type rsp_in;
   logic             rv_ff;
   cir_pkg::rsp_type rsp_ff;

   always_comb begin
      logic signed [55:0] ra, rb;
      logic signed [61:0] ua, ub;
      logic signed [33:0] va_c, vb_c;
      rsp_in = '0;
      for (int i = 0; i < 3; i++) begin
         ra = (pa_ff[i] + 56'sd536870912 - (pa_ff[i][55] ? 56'sd1 : 56'sd0)) >>> 30;
         rb = (pb_ff[i] + 56'sd536870912 - (pb_ff[i][55] ? 56'sd1 : 56'sd0)) >>> 30;
         ua = (qa_ff[i] + 62'sd536870912 - (qa_ff[i][61] ? 62'sd1 : 62'sd0)) >>> 30;
         ub = (qb_ff[i] + 62'sd536870912 - (qb_ff[i][61] ? 62'sd1 : 62'sd0)) >>> 30;
         va_c = 34'($signed(vap_ff[20*i +: 20]));
         vb_c = 34'($signed(vbp_ff[20*i +: 20]));
         if (zp_ff) begin
            rsp_in.new_vel_a[20*i +: 20] = vap_ff[20*i +: 20];
            rsp_in.new_vel_b[20*i +: 20] = vbp_ff[20*i +: 20];
         end else begin
            rsp_in.shift_a[20*i +: 20] = cir_pkg::sat20(-ra[33:0]);
            rsp_in.shift_b[20*i +: 20] = cir_pkg::sat20(rb[33:0]);
            if (sp_ff) begin
               rsp_in.new_vel_a[20*i +: 20] = vap_ff[20*i +: 20];
               rsp_in.new_vel_b[20*i +: 20] = vbp_ff[20*i +: 20];
            end else begin
               rsp_in.new_vel_a[20*i +: 20] = cir_pkg::sat20(va_c - ua[33:0]);
               rsp_in.new_vel_b[20*i +: 20] = cir_pkg::sat20(vb_c + ub[33:0]);
            end
         end
      end
      if (zp_ff)      rsp_in.outcome = cir_pkg::OUT_STATIC;
      else if (sp_ff) rsp_in.outcome = cir_pkg::OUT_SEPARATE;
      else            rsp_in.outcome = cir_pkg::OUT_IMPULSE;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= vp_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/cir_div.sv @@
// cir_div: pipelined restoring divider, one quotient bit per stage.
// Depends on cir_pkg.
module cir_div (
   input  logic                        clock,
   input  logic [cir_pkg::DIVD_W-1:0]  dividend,
   input  logic [cir_pkg::DSR_W-1:0]   divisor,
   output logic [cir_pkg::QUO_W-1:0]   quotient
);

   localparam int Q = cir_pkg::QUO_W;
   localparam int RW = cir_pkg::DIVD_W;

   logic [RW-1:0]                 rem_ff [Q];
   logic [cir_pkg::DSR_W-1:0]     dsr_ff [Q];
   logic [Q-1:0]                  quo_ff [Q];

   for (genvar k = 0; k < Q; k++) begin : g_stage
      logic [RW-1:0]             r_src;
      logic [cir_pkg::DSR_W-1:0] d_src;
      logic [Q-1:0]              q_src;
      logic [RW:0]               trial;
      logic [RW-1:0]             rem_in;
      logic [Q-1:0]              quo_in;

      if (k == 0) begin : g_first
         assign r_src = dividend;
         assign d_src = divisor;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[k-1];
         assign d_src = dsr_ff[k-1];
         assign q_src = quo_ff[k-1];
      end

      // trial subtract of divisor aligned to quotient bit Q-1-k
      assign trial = {1'b0, r_src} - ({{(RW+1-cir_pkg::DSR_W){1'b0}}, d_src} << (Q-1-k));

      always_comb begin
         rem_in = r_src;
         quo_in = q_src;
         if (!trial[RW]) begin
            rem_in = trial[RW-1:0];
            quo_in[Q-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         dsr_ff[k] <= d_src;
         quo_ff[k] <= quo_in;
      end
   end

   assign quotient = quo_ff[Q-1];

endmodule

@@ src/cir_checker.sv @@
// cir_checker: port-level assertions for contact_impulse_resolver, with bind.
// Depends on cir_pkg.
module cir_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input cir_pkg::rsp_type rsp_data
);

   // a flushed pipeline shows no result right after reset
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // every result comes from an item taken a fixed latency earlier; the check looks
   // back from the sample of the strobe to the sample of its accept
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, cir_pkg::LATENCY + 1))
      else $error("result without matching item");

   // immovable pair gets no position correction
   a_static_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == cir_pkg::OUT_STATIC
      |-> rsp_data.shift_a == '0 && rsp_data.shift_b == '0)
      else $error("shift on immovable pair");

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
